// ----- hdl/lsuf_pkg.sv -----
// ----------------------------------------------------------------------------
// lsuf_pkg: shared types and codes for the logic and shift unit
// Request and response structs, operation codes, flag bit positions, pc advance values and register file sizing.
// ----------------------------------------------------------------------------
package lsuf_pkg;

   // Register file sizing
   localparam int NUM_REGS = 32;
   localparam int REG_AW   = $clog2(NUM_REGS);

   // Flag register bit positions
   localparam int FLAG_Z  = 0;
   localparam int FLAG_S  = 1;
   localparam int FLAG_OV = 2;
   localparam int FLAG_CY = 3;

   // Operation codes
   localparam logic [4:0] OP_SET     = 5'd0;
   localparam logic [4:0] OP_OR      = 5'd1;
   localparam logic [4:0] OP_AND     = 5'd2;
   localparam logic [4:0] OP_TST     = 5'd3;
   localparam logic [4:0] OP_NOT     = 5'd4;
   localparam logic [4:0] OP_XOR     = 5'd5;
   localparam logic [4:0] OP_ZXB     = 5'd6;
   localparam logic [4:0] OP_ZXH     = 5'd7;
   localparam logic [4:0] OP_SXB     = 5'd8;
   localparam logic [4:0] OP_SXH     = 5'd9;
   localparam logic [4:0] OP_SHL_IMM = 5'd10;
   localparam logic [4:0] OP_SHR_IMM = 5'd11;
   localparam logic [4:0] OP_SAR_IMM = 5'd12;
   localparam logic [4:0] OP_ANDI    = 5'd13;
   localparam logic [4:0] OP_ORI     = 5'd14;
   localparam logic [4:0] OP_XORI    = 5'd15;
   localparam logic [4:0] OP_SHL_REG = 5'd16;
   localparam logic [4:0] OP_SHR_REG = 5'd17;
   localparam logic [4:0] OP_SAR_REG = 5'd18;

   // Program counter advance values
   localparam logic [2:0] PC_NONE  = 3'd0;
   localparam logic [2:0] PC_SHORT = 3'd2;
   localparam logic [2:0] PC_LONG  = 3'd4;

   typedef struct packed {
      logic [4:0]  operation;
      logic [4:0]  src_reg;
      logic [4:0]  dst_reg;
      logic [15:0] immediate;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        zero_flag;
      logic        sign_flag;
      logic        overflow_flag;
      logic        carry_flag;
      logic [2:0]  pc_advance;
   } rsp_type;

endpackage

// ----- hdl/logic_shift_unit_with_flags_top.sv -----
// ----------------------------------------------------------------------------
// logic_shift_unit_with_flags_top: logic, extension and shift execute unit
// Pipeline: the register file is read into the execute stage at the accept
//   edge, then execute and write back into the response register.
// Throughput: one request per cycle unless rsp_ready stalls; a write in
//   execute is forwarded to the next request's operands, read in that same cycle.
// Reset: clears flags, register valid bits and pipeline valids at once; an
//   entry never written reads as zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module logic_shift_unit_with_flags_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lsuf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lsuf_pkg::rsp_type rsp_data
);

   localparam int AW = lsuf_pkg::REG_AW;

   // Register file storage and valid bits
   logic [31:0]                 mem [lsuf_pkg::NUM_REGS];
   logic [lsuf_pkg::NUM_REGS-1:0] valid_ff;

   // Read stage registers
   logic [31:0]       rd_a_ff;
   logic [31:0]       rd_b_ff;
   logic              rd_a_vld_ff;
   logic              rd_b_vld_ff;
   logic              s1_vld_ff;
   lsuf_pkg::req_type s1_req_ff;

   // Last write, forwarded to the following request
   logic              fwd_vld_ff;
   logic [AW-1:0]     fwd_addr_ff;
   logic [31:0]       fwd_data_ff;

   // Flags and response register
   logic [3:0]        flag_ff;
   logic [3:0]        flag_in;
   logic              rsp_vld_ff;
   lsuf_pkg::rsp_type rsp_ff;
   lsuf_pkg::rsp_type rsp_in;

   // Handshake and write-back control
   logic              req_fire;
   logic              s1_adv;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [31:0]       wr_data;
   logic [AW-1:0]     src_idx;
   logic [AW-1:0]     dst_idx;
   logic [AW-1:0]     s1_src_idx;
   logic [AW-1:0]     s1_dst_idx;
   logic              s_ok;
   logic              d_ok;
   logic [31:0]       opa;
   logic [31:0]       opb;

   // Advance execute when the response register is free or being drained
   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign src_idx    = req_data.src_reg[AW-1:0];
   assign dst_idx    = req_data.dst_reg[AW-1:0];
   assign s1_src_idx = s1_req_ff.src_reg[AW-1:0];
   assign s1_dst_idx = s1_req_ff.dst_reg[AW-1:0];
   assign s_ok = 32'(s1_req_ff.src_reg) < 32'(lsuf_pkg::NUM_REGS);
   assign d_ok = 32'(s1_req_ff.dst_reg) < 32'(lsuf_pkg::NUM_REGS);

   // Register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req_fire) begin
         rd_a_ff <= mem[src_idx];
         rd_b_ff <= mem[dst_idx];
      end
   end

   // Track written entries; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Capture the request into the execute stage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff   <= req_data;
         rd_a_vld_ff <= valid_ff[src_idx];
         rd_b_vld_ff <= valid_ff[dst_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   // Pick operands, forwarding the write made in the same cycle as the read
   always_comb begin
      opa = rd_a_vld_ff ? rd_a_ff : 32'd0;
      opb = rd_b_vld_ff ? rd_b_ff : 32'd0;
      if (fwd_vld_ff && fwd_addr_ff == s1_src_idx) begin
         opa = fwd_data_ff;
      end
      if (fwd_vld_ff && fwd_addr_ff == s1_dst_idx) begin
         opb = fwd_data_ff;
      end
   end

   // Execute: compute result, flags, write-back and pc advance
   always_comb begin
      logic [4:0]  sh;
      logic [31:0] sres;
      logic        scy;
      logic [31:0] res;
      logic        set_zs;
      logic        is_shift;
      logic        ok;
      logic [2:0]  pc;
      logic        we;
      logic [AW-1:0] wa;

      sh       = 5'd0;
      sres     = opb;
      scy      = 1'b0;
      res      = 32'd0;
      set_zs   = 1'b0;
      is_shift = 1'b0;
      ok       = 1'b0;
      pc       = lsuf_pkg::PC_NONE;
      we       = 1'b0;
      wa       = s1_dst_idx;

      // Shift amount from the immediate or from the source register
      if (s1_req_ff.operation == lsuf_pkg::OP_SHL_REG ||
          s1_req_ff.operation == lsuf_pkg::OP_SHR_REG ||
          s1_req_ff.operation == lsuf_pkg::OP_SAR_REG) begin
         sh = opa[4:0];
      end else begin
         sh = s1_req_ff.immediate[4:0];
      end

      // Barrel shift with the last bit shifted out as carry
      if (sh != 5'd0) begin
         case (s1_req_ff.operation) inside
            lsuf_pkg::OP_SHL_IMM, lsuf_pkg::OP_SHL_REG: begin
               sres = opb << sh;
               scy  = opb[5'd0 - sh];
            end
            lsuf_pkg::OP_SAR_IMM, lsuf_pkg::OP_SAR_REG: begin
               sres = 32'($signed(opb) >>> sh);
               scy  = opb[sh - 5'd1];
            end
            default: begin
               sres = opb >> sh;
               scy  = opb[sh - 5'd1];
            end
         endcase
      end

      case (s1_req_ff.operation) inside
         lsuf_pkg::OP_SET: begin
            ok  = d_ok;
            res = s1_req_ff.write_data;
            we  = d_ok;
         end
         lsuf_pkg::OP_OR, lsuf_pkg::OP_AND, lsuf_pkg::OP_TST,
         lsuf_pkg::OP_NOT, lsuf_pkg::OP_XOR: begin
            ok = s_ok && d_ok;
            case (s1_req_ff.operation)
               lsuf_pkg::OP_OR:  res = opa | opb;
               lsuf_pkg::OP_NOT: res = ~opa;
               lsuf_pkg::OP_XOR: res = opa ^ opb;
               default:          res = opa & opb;
            endcase
            set_zs = ok;
            we     = ok && (s1_req_ff.operation != lsuf_pkg::OP_TST);
            pc     = lsuf_pkg::PC_SHORT;
         end
         lsuf_pkg::OP_ZXB, lsuf_pkg::OP_ZXH,
         lsuf_pkg::OP_SXB, lsuf_pkg::OP_SXH: begin
            ok = s_ok;
            case (s1_req_ff.operation)
               lsuf_pkg::OP_ZXB: res = {24'd0, opa[7:0]};
               lsuf_pkg::OP_ZXH: res = {16'd0, opa[15:0]};
               lsuf_pkg::OP_SXB: res = {{24{opa[7]}}, opa[7:0]};
               default:          res = {{16{opa[15]}}, opa[15:0]};
            endcase
            we = ok;
            wa = s1_src_idx;
            pc = lsuf_pkg::PC_SHORT;
         end
         lsuf_pkg::OP_SHL_IMM, lsuf_pkg::OP_SHR_IMM, lsuf_pkg::OP_SAR_IMM: begin
            ok       = d_ok;
            res      = sres;
            set_zs   = ok;
            is_shift = ok;
            we       = ok;
            pc       = lsuf_pkg::PC_SHORT;
         end
         lsuf_pkg::OP_ANDI, lsuf_pkg::OP_ORI, lsuf_pkg::OP_XORI: begin
            ok = s_ok && d_ok;
            case (s1_req_ff.operation)
               lsuf_pkg::OP_ANDI: res = opa & {16'd0, s1_req_ff.immediate};
               lsuf_pkg::OP_ORI:  res = opa | {16'd0, s1_req_ff.immediate};
               default:           res = opa ^ {16'd0, s1_req_ff.immediate};
            endcase
            set_zs = ok;
            we     = ok;
            pc     = lsuf_pkg::PC_LONG;
         end
         lsuf_pkg::OP_SHL_REG, lsuf_pkg::OP_SHR_REG, lsuf_pkg::OP_SAR_REG: begin
            ok       = s_ok && d_ok;
            res      = sres;
            set_zs   = ok;
            is_shift = ok;
            we       = ok;
            pc       = lsuf_pkg::PC_LONG;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      // Drop everything for an out-of-range register or an unknown code
      if (!ok) begin
         res    = 32'd0;
         set_zs = 1'b0;
         is_shift = 1'b0;
         we     = 1'b0;
         pc     = lsuf_pkg::PC_NONE;
      end

      flag_in = flag_ff;
      if (set_zs) begin
         flag_in[lsuf_pkg::FLAG_Z]  = (res == 32'd0);
         flag_in[lsuf_pkg::FLAG_S]  = res[31];
         flag_in[lsuf_pkg::FLAG_OV] = 1'b0;
      end
      if (is_shift) begin
         flag_in[lsuf_pkg::FLAG_CY] = scy;
      end

      rsp_in.result_value  = res;
      rsp_in.zero_flag     = flag_in[lsuf_pkg::FLAG_Z];
      rsp_in.sign_flag     = flag_in[lsuf_pkg::FLAG_S];
      rsp_in.overflow_flag = flag_in[lsuf_pkg::FLAG_OV];
      rsp_in.carry_flag    = flag_in[lsuf_pkg::FLAG_CY];
      rsp_in.pc_advance    = pc;

      wr_en   = s1_adv && we;
      wr_addr = wa;
      wr_data = res;
   end

   // Commit flags, forwarding entry and response
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff    <= '0;
         fwd_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            flag_ff <= flag_in;
         end
         if (wr_en) begin
            fwd_vld_ff <= 1'b1;
         end
         if (s1_adv) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // A blocked response must hold the execute stage and the request side
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && rsp_vld_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while execute stage is blocked");

   // No operation of this unit ever sets overflow
   a_overflow_clear: assert property (@(posedge clock) disable iff (reset)
      !flag_ff[lsuf_pkg::FLAG_OV])
      else $error("overflow flag set");

   // Instruction length is none, short or long
   a_pc_values: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.pc_advance == lsuf_pkg::PC_NONE ||
                      rsp_ff.pc_advance == lsuf_pkg::PC_SHORT ||
                      rsp_ff.pc_advance == lsuf_pkg::PC_LONG))
      else $error("bad pc advance");

   // A retiring request always leaves a response behind
   a_retire_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_vld_ff)
      else $error("response lost after retire");
`endif

endmodule

// ----- bench/lsuf_result_checker.sv -----
// ----------------------------------------------------------------------------
// lsuf_result_checker: response checker for the logic and shift unit
// Mirrors the register file and flag register, works out the response for
// every accepted request, and compares every accepted response field by field
// against the oldest outstanding one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsuf_result_checker
   import lsuf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   logic [31:0] gpr_mirror [NUM_REGS];
   logic [3:0]  flag_mirror;
   rsp_type     pending_results [$];
   rsp_type     oldest;
   int          rsp_index;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR t=%0t response %0d: %s got %h expected %h",
               $time, rsp_index, what, got, want);
      fail_count++;
   endtask

   function automatic void update_zero_sign(input logic [31:0] value);
      flag_mirror[FLAG_Z]  = (value == 32'h0);
      flag_mirror[FLAG_S]  = value[31];
      flag_mirror[FLAG_OV] = 1'b0;
   endfunction

   // Shift by a 5-bit amount; bit 32 carries the last bit shifted out
   function automatic logic [32:0] shift_with_carry(input logic [4:0]  op,
                                                    input logic [31:0] value,
                                                    input logic [4:0]  amount);
      logic [31:0] res;
      logic        cy;
      res = value;
      cy  = 1'b0;
      if (amount != 5'd0) begin
         case (op)
            OP_SHL_IMM, OP_SHL_REG: begin
               res = value << amount;
               cy  = value[32 - amount];
            end
            OP_SHR_IMM, OP_SHR_REG: begin
               res = value >> amount;
               cy  = value[amount - 1];
            end
            default: begin
               res = $signed(value) >>> amount;
               cy  = value[amount - 1];
            end
         endcase
      end
      return {cy, res};
   endfunction

   // Execute one instruction against the mirrored state
   function automatic rsp_type execute_op(input req_type rq);
      rsp_type     rs;
      logic [31:0] a, b, res;
      logic [32:0] shifted;
      logic        s_ok, d_ok;
      s_ok = (rq.src_reg < NUM_REGS);
      d_ok = (rq.dst_reg < NUM_REGS);
      a    = s_ok ? gpr_mirror[rq.src_reg] : 32'h0;
      b    = d_ok ? gpr_mirror[rq.dst_reg] : 32'h0;
      res  = 32'h0;
      rs.pc_advance = PC_NONE;
      case (rq.operation)
         OP_SET: begin
            if (d_ok) begin
               gpr_mirror[rq.dst_reg] = rq.write_data;
               res = rq.write_data;
            end
         end
         OP_OR, OP_AND, OP_TST, OP_NOT, OP_XOR: begin
            if (s_ok && d_ok) begin
               case (rq.operation)
                  OP_OR:   res = a | b;
                  OP_NOT:  res = ~a;
                  OP_XOR:  res = a ^ b;
                  default: res = a & b;
               endcase
               update_zero_sign(res);
               // tst only sets flags
               if (rq.operation != OP_TST) gpr_mirror[rq.dst_reg] = res;
               rs.pc_advance = PC_SHORT;
            end
         end
         OP_ZXB, OP_ZXH, OP_SXB, OP_SXH: begin
            if (s_ok) begin
               case (rq.operation)
                  OP_ZXB:  res = {24'h0, a[7:0]};
                  OP_ZXH:  res = {16'h0, a[15:0]};
                  OP_SXB:  res = {{24{a[7]}}, a[7:0]};
                  default: res = {{16{a[15]}}, a[15:0]};
               endcase
               // extensions rewrite the source in place, flags untouched
               gpr_mirror[rq.src_reg] = res;
               rs.pc_advance = PC_SHORT;
            end
         end
         OP_SHL_IMM, OP_SHR_IMM, OP_SAR_IMM: begin
            if (d_ok) begin
               shifted = shift_with_carry(rq.operation, b, rq.immediate[4:0]);
               res = shifted[31:0];
               flag_mirror[FLAG_CY] = shifted[32];
               update_zero_sign(res);
               gpr_mirror[rq.dst_reg] = res;
               rs.pc_advance = PC_SHORT;
            end
         end
         OP_ANDI, OP_ORI, OP_XORI: begin
            if (s_ok && d_ok) begin
               case (rq.operation)
                  OP_ANDI: res = a & {16'h0, rq.immediate};
                  OP_ORI:  res = a | {16'h0, rq.immediate};
                  default: res = a ^ {16'h0, rq.immediate};
               endcase
               update_zero_sign(res);
               gpr_mirror[rq.dst_reg] = res;
               rs.pc_advance = PC_LONG;
            end
         end
         OP_SHL_REG, OP_SHR_REG, OP_SAR_REG: begin
            if (s_ok && d_ok) begin
               shifted = shift_with_carry(rq.operation, b, a[4:0]);
               res = shifted[31:0];
               flag_mirror[FLAG_CY] = shifted[32];
               update_zero_sign(res);
               gpr_mirror[rq.dst_reg] = res;
               rs.pc_advance = PC_LONG;
            end
         end
         default: begin
            // unused codes change nothing and report current flags
         end
      endcase
      rs.result_value  = res;
      rs.zero_flag     = flag_mirror[FLAG_Z];
      rs.sign_flag     = flag_mirror[FLAG_S];
      rs.overflow_flag = flag_mirror[FLAG_OV];
      rs.carry_flag    = flag_mirror[FLAG_CY];
      return rs;
   endfunction

   // Track both channels; compare before predicting so a same-edge
   // request never answers a response
   always @(posedge clock) begin
      if (reset) begin
         foreach (gpr_mirror[i]) gpr_mirror[i] = 32'h0;
         flag_mirror = 4'h0;
         pending_results.delete();
         fail_count    = 0;
         pending_count = 0;
         rsp_index     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unrequested response", rsp_data.result_value, 32'h0);
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_data.result_value !== oldest.result_value)
                  report_mismatch("result_value", rsp_data.result_value,
                                  oldest.result_value);
               if (rsp_data.zero_flag !== oldest.zero_flag)
                  report_mismatch("zero_flag", 32'(rsp_data.zero_flag),
                                  32'(oldest.zero_flag));
               if (rsp_data.sign_flag !== oldest.sign_flag)
                  report_mismatch("sign_flag", 32'(rsp_data.sign_flag),
                                  32'(oldest.sign_flag));
               if (rsp_data.overflow_flag !== oldest.overflow_flag)
                  report_mismatch("overflow_flag", 32'(rsp_data.overflow_flag),
                                  32'(oldest.overflow_flag));
               if (rsp_data.carry_flag !== oldest.carry_flag)
                  report_mismatch("carry_flag", 32'(rsp_data.carry_flag),
                                  32'(oldest.carry_flag));
               if (rsp_data.pc_advance !== oldest.pc_advance)
                  report_mismatch("pc_advance", 32'(rsp_data.pc_advance),
                                  32'(oldest.pc_advance));
            end
            rsp_index++;
         end
         if (req_valid && req_ready) pending_results.push_back(execute_op(req_data));
         pending_count = pending_results.size();
      end
   end

endmodule

// ----- bench/tb_logic_shift_unit_with_flags_top.sv -----
// ----------------------------------------------------------------------------
// tb_logic_shift_unit_with_flags_top: testbench for the logic and shift unit
// Drives a directed set of instructions and then a long random mix in bursts,
// while the response side stalls on its own pattern and once holds off long
// enough to back the unit up. A side checker predicts and compares responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_logic_shift_unit_with_flags_top;
   import lsuf_pkg::*;

   localparam int         RANDOM_ITEMS    = 1400;
   localparam int         HOLD_OFF_CYCLES = 80;
   localparam int         DRAIN_CYCLES    = 10;
   localparam int         CYCLE_LIMIT     = 200000;
   localparam logic [4:0] OP_FIRST_UNUSED = 5'd19;
   localparam logic [4:0] OP_LAST_UNUSED  = 5'd31;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      burst_left;
   int      cycle_count = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic_shift_unit_with_flags_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   lsuf_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("logic_shift_unit_with_flags_top test failed");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [4:0]  op,
                                        input logic [4:0]  src,
                                        input logic [4:0]  dst,
                                        input logic [15:0] imm,
                                        input logic [31:0] wd);
      req_type r;
      r.operation  = op;
      r.src_reg    = src;
      r.dst_reg    = dst;
      r.immediate  = imm;
      r.write_data = wd;
      return r;
   endfunction

   // Mostly real instructions on a few hot registers, some sets to seed
   // interesting values, and a few unused codes
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.src_reg   = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      r.dst_reg   = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      r.immediate = 16'($urandom);
      case ($urandom_range(0, 7))
         0:       r.immediate[4:0] = 5'h00;
         1:       r.immediate[4:0] = 5'h1F;
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0:       r.write_data = 32'h0000_0000;
         1:       r.write_data = 32'hFFFF_FFFF;
         2:       r.write_data = 32'h8000_0000;
         3:       r.write_data = 32'h1 << $urandom_range(0, 31);
         4:       r.write_data = 32'($urandom_range(0, 40));
         default: r.write_data = $urandom;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 15)
         r.operation = OP_SET;
      else if (pick < 96)
         r.operation = 5'($urandom_range(OP_OR, OP_SAR_REG));
      else
         r.operation = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      return r;
   endfunction

   // Offer one request at the falling edge and hold it until accepted;
   // open a random gap whenever the current burst runs out
   task automatic issue_request(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Response side: phases of free flow, fixed masks and random stalls,
   // with one long hold-off to fill the pipeline
   initial begin : receiver
      int          mode;
      int          span;
      int          k;
      int          phase_count;
      logic [31:0] mask;
      rsp_ready   = 1'b0;
      phase_count = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (phase_count == 3) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         mask = $urandom;
         for (k = 0; k < span; k++) begin
            case (mode)
               0:       rsp_ready = 1'b1;
               1:       rsp_ready = mask[k % 32];
               2:       rsp_ready = ($urandom_range(0, 3) != 0);
               default: rsp_ready = ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
         phase_count++;
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      int n;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      burst_left = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Seed registers with edge values
      issue_request(make_req(OP_SET, 5'd0, 5'd1, 16'h0000, 32'hFFFF_FFFF));
      issue_request(make_req(OP_SET, 5'd0, 5'd2, 16'hFFFF, 32'h8000_0000));
      issue_request(make_req(OP_SET, 5'd0, 5'd4, 16'h0000, 32'h0000_8080));
      issue_request(make_req(OP_SET, 5'd0, 5'd7, 16'h0000, 32'h8000_0001));
      issue_request(make_req(OP_SET, 5'd0, 5'd8, 16'h0000, 32'h0000_0020));
      issue_request(make_req(OP_SET, 5'd0, 5'd9, 16'h0000, 32'h0000_001F));
      // Register logic: sign result, zero result, tst without write-back
      issue_request(make_req(OP_OR,  5'd2, 5'd3,  16'h0000, 32'h0));
      issue_request(make_req(OP_AND, 5'd1, 5'd2,  16'h0000, 32'h0));
      issue_request(make_req(OP_TST, 5'd10, 5'd3, 16'h0000, 32'h0));
      issue_request(make_req(OP_NOT, 5'd1, 5'd5,  16'h0000, 32'h0));
      issue_request(make_req(OP_XOR, 5'd3, 5'd3,  16'h0000, 32'h0));
      // Extensions on a value with bits 7 and 15 set
      issue_request(make_req(OP_SXB, 5'd4, 5'd0, 16'h0000, 32'h0));
      issue_request(make_req(OP_ZXH, 5'd4, 5'd0, 16'h0000, 32'h0));
      issue_request(make_req(OP_SXH, 5'd4, 5'd0, 16'h0000, 32'h0));
      issue_request(make_req(OP_ZXB, 5'd4, 5'd0, 16'h0000, 32'h0));
      // Immediate shifts: zero amount clears carry, negative arithmetic shift
      issue_request(make_req(OP_SHL_IMM, 5'd0, 5'd2, 16'hFFE0, 32'h0));
      issue_request(make_req(OP_SAR_IMM, 5'd0, 5'd7, 16'h0004, 32'h0));
      issue_request(make_req(OP_SHR_IMM, 5'd0, 5'd2, 16'h001F, 32'h0));
      issue_request(make_req(OP_SHL_IMM, 5'd0, 5'd7, 16'h001F, 32'h0));
      // Immediate logic at both ends of the immediate
      issue_request(make_req(OP_ANDI, 5'd1, 5'd11, 16'hFFFF, 32'h0));
      issue_request(make_req(OP_ORI,  5'd3, 5'd12, 16'h0000, 32'h0));
      issue_request(make_req(OP_XORI, 5'd1, 5'd13, 16'hFFFF, 32'h0));
      // Register shifts: amount 31, and an amount that masks to zero
      issue_request(make_req(OP_SHL_REG, 5'd9, 5'd1, 16'h0000, 32'h0));
      issue_request(make_req(OP_SHR_REG, 5'd8, 5'd1, 16'h0000, 32'h0));
      issue_request(make_req(OP_SAR_REG, 5'd9, 5'd7, 16'h0000, 32'h0));
      // Unused codes do nothing
      issue_request(make_req(OP_FIRST_UNUSED, 5'd1, 5'd2, 16'hFFFF, 32'hFFFF_FFFF));
      issue_request(make_req(OP_LAST_UNUSED,  5'd31, 5'd31, 16'h0000, 32'h0));

      for (n = 0; n < RANDOM_ITEMS; n++) issue_request(random_request());

      // Drain outstanding responses, then let the pipeline settle
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("logic_shift_unit_with_flags_top test passed");
      end else begin
         $display("logic_shift_unit_with_flags_top test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/lsuf_pkg.sv
hdl/logic_shift_unit_with_flags_top.sv
bench/lsuf_result_checker.sv
bench/tb_logic_shift_unit_with_flags_top.sv
